### hdl/lbc_pkg.sv
// shared constants and lattice tables for the d2q9 bgk collision pipeline
package lbc_pkg;

  localparam int NDIR      = 9;
  localparam int U_FRAC    = 30;
  localparam int OUT_SHIFT = 46;
  localparam int OMEGA_W   = 17;
  localparam logic [OMEGA_W-1:0] OMEGA_RESET = 17'd109227;

  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;
  localparam int NUM_W  = 62;
  localparam int DEN_W  = 32;
  localparam int QUO_W  = 31;

  localparam int P_W    = 40;
  localparam int X_W    = P_W + 3;
  localparam int Y_W    = 40;
  localparam int RCP_SH = 48;
  localparam int RCP_W  = 45;
  localparam int RCP_LO = 24;
  localparam int WP_W   = 40;
  localparam int K_W    = 58;
  localparam int KLO_W  = 29;

  localparam int DIR_X  [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y  [NDIR] = '{0, 0, -1, 0, 1, -1, -1, 1, 1};
  localparam int WT_NUM [NDIR] = '{4, 1, 1, 1, 1, 1, 1, 1, 1};
  localparam int WT_DEN [NDIR] = '{9, 9, 9, 9, 9, 36, 36, 36, 36};

  localparam logic [RCP_W-1:0] RCP_9  = RCP_W'(((64'd1 << RCP_SH) + 64'd8) / 64'd9);
  localparam logic [RCP_W-1:0] RCP_36 = RCP_W'(((64'd1 << RCP_SH) + 64'd35) / 64'd36);

endpackage

### hdl/d2q9_bgk_collision.sv
// top level of the d2q9 bgk collision pipeline
// Takes one lattice cell (nine signed distributions) per cycle unless stalled
// and returns the nine relaxed distributions plus a flag for a capped speed.
// Throughput is one cell per clock while the output is not stalled; the depth
// is set by the 32-stage square root and the 31-stage velocity divider in the
// middle of the pipeline. A stall on the output freezes the whole pipeline;
// the input is ready whenever the output register is empty or being taken.
// omega may be written at any time the pipeline holds no cells.
module d2q9_bgk_collision import lbc_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // f_rest, f_east, f_north, f_west, f_south, f_northeast, f_northwest,
  // f_southwest, f_southeast, zero fill
  input  logic [((NDIR*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // g_rest, g_east, g_north, g_west, g_south, g_northeast, g_northwest,
  // g_southwest, g_southeast, zero fill
  output logic [((NDIR*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
  // speed_capped
  output logic                 m_tuser,
  input  logic                 cfg_we_i,
  input  logic [OMEGA_W-1:0]   cfg_wdata_i
);

  localparam int DW   = DATA_WIDTH;
  localparam int TD_W = ((NDIR * DW + 7) / 8) * 8;
  localparam int SW   = DW + 4;
  localparam int NW   = (SW > U_FRAC) ? SW : U_FRAC;
  localparam int SHW  = $clog2(SW);
  localparam int FCW  = DW + 18;
  localparam int PLW  = SW + KLO_W + 1;
  localparam int PHW  = SW + K_W - KLO_W;
  localparam int TW   = DW + 64;
  localparam int PR_W = Y_W + RCP_W;
  localparam int LAT  = 5 + ROOT_W + 1 + QUO_W + 11;
  localparam logic signed [TW-1:0] RND  = TW'(1) << (OUT_SHIFT - 1);
  localparam logic signed [TW-1:0] GMAX = {{(TW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [TW-1:0] GMIN = ~GMAX;

  typedef struct packed {
    logic [NDIR-1:0][DW-1:0] f;
    logic [SW-1:0]           rho;
    logic [U_FRAC-1:0]       a;
    logic [U_FRAC-1:0]       bx;
    logic [U_FRAC-1:0]       by;
    logic                    capped;
    logic                    sx;
    logic                    sy;
    logic                    nz;
  } side_t;

  typedef struct packed {
    logic [NDIR-1:0][DW-1:0] f;
    logic [SW-1:0]           rho;
    logic                    capped;
  } post_t;

  localparam int TAG_W = $bits(side_t);

  logic               adv;
  logic [LAT-1:0]     vld_q;
  logic [OMEGA_W-1:0] omega_q;

  assign adv      = !vld_q[LAT-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      omega_q <= OMEGA_RESET;
    end else begin
      if (adv) vld_q <= {vld_q[LAT-2:0], s_tvalid};
      if (cfg_we_i) omega_q <= cfg_wdata_i;
    end
  end

  // density and momentum
  logic [NDIR-1:0][DW-1:0] f_in, f1_q;
  logic signed [SW-1:0]    rho1_d, mx1_d, my1_d, rho1_q, mx1_q, my1_q;

  assign f_in = s_tdata[NDIR*DW-1:0];

  always_comb begin
    logic signed [SW-1:0] fx;
    rho1_d = '0;
    mx1_d  = '0;
    my1_d  = '0;
    for (int i = 0; i < NDIR; i++) begin
      fx = SW'($signed(f_in[i]));
      rho1_d = rho1_d + fx;
      if (DIR_X[i] > 0) mx1_d = mx1_d + fx;
      else if (DIR_X[i] < 0) mx1_d = mx1_d - fx;
      if (DIR_Y[i] > 0) my1_d = my1_d + fx;
      else if (DIR_Y[i] < 0) my1_d = my1_d - fx;
    end
  end

  // sign fold and magnitudes
  logic [SW-1:0] am2_d, bxm2_d, bym2_d, am2_q, bxm2_q, bym2_q;
  side_t         side2_d, side2_q;

  always_comb begin
    logic                 negr;
    logic signed [SW-1:0] mxn, myn, rn;
    negr = rho1_q[SW-1];
    rn   = negr ? -rho1_q : rho1_q;
    mxn  = negr ? -mx1_q : mx1_q;
    myn  = negr ? -my1_q : my1_q;
    am2_d  = rn;
    bxm2_d = mxn[SW-1] ? -mxn : mxn;
    bym2_d = myn[SW-1] ? -myn : myn;
    side2_d        = '0;
    side2_d.f      = f1_q;
    side2_d.rho    = rho1_q;
    side2_d.sx     = mxn[SW-1];
    side2_d.sy     = myn[SW-1];
    side2_d.nz     = |rho1_q;
  end

  // common right shift below 2^30
  side_t side3_d, side3_q;

  always_comb begin
    logic [SW-1:0]  o;
    logic [SHW-1:0] sh;
    o  = am2_q | bxm2_q | bym2_q;
    sh = '0;
    for (int i = U_FRAC; i < SW; i++) begin
      if (o[i]) sh = SHW'(i - U_FRAC + 1);
    end
    side3_d    = side2_q;
    side3_d.a  = U_FRAC'(NW'(am2_q) >> sh);
    side3_d.bx = U_FRAC'(NW'(bxm2_q) >> sh);
    side3_d.by = U_FRAC'(NW'(bym2_q) >> sh);
  end

  // squares
  logic [2*U_FRAC-1:0] sqx4_q, sqy4_q, aa4_q;
  side_t               side4_q;

  // speed test, never capped at zero density
  logic [RAD_W-1:0] q3_d, q3_q;
  side_t            side5_d, side5_q;

  always_comb begin
    q3_d = RAD_W'(3) * (RAD_W'(sqx4_q) + RAD_W'(sqy4_q));
    side5_d        = side4_q;
    side5_d.capped = side4_q.nz && (q3_d > RAD_W'(aa4_q));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_q    <= f_in;
      rho1_q  <= rho1_d;
      mx1_q   <= mx1_d;
      my1_q   <= my1_d;
      am2_q   <= am2_d;
      bxm2_q  <= bxm2_d;
      bym2_q  <= bym2_d;
      side2_q <= side2_d;
      side3_q <= side3_d;
      sqx4_q  <= (2*U_FRAC)'(side3_q.bx) * (2*U_FRAC)'(side3_q.bx);
      sqy4_q  <= (2*U_FRAC)'(side3_q.by) * (2*U_FRAC)'(side3_q.by);
      aa4_q   <= (2*U_FRAC)'(side3_q.a) * (2*U_FRAC)'(side3_q.a);
      side4_q <= side3_q;
      q3_q    <= q3_d;
      side5_q <= side5_d;
    end
  end

  logic [ROOT_W-1:0] root6;
  logic [TAG_W-1:0]  tag6;
  side_t             side6;

  lbc_isqrt #(
    .TAG_W (TAG_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (q3_q),
    .tag_i  (side5_q),
    .root_o (root6),
    .tag_o  (tag6)
  );

  assign side6 = side_t'(tag6);

  // divisor and rounded numerators
  logic [DEN_W-1:0] d7_d, d7_q;
  logic [NUM_W-1:0] nx7_d, ny7_d, nx7_q, ny7_q;
  side_t            side7_q;

  always_comb begin
    d7_d  = side6.capped ? DEN_W'(root6) : DEN_W'(side6.a);
    nx7_d = (NUM_W'(side6.bx) << U_FRAC) + NUM_W'(d7_d >> 1);
    ny7_d = (NUM_W'(side6.by) << U_FRAC) + NUM_W'(d7_d >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d7_q    <= d7_d;
      nx7_q   <= nx7_d;
      ny7_q   <= ny7_d;
      side7_q <= side6;
    end
  end

  logic [QUO_W-1:0] qx8, qy8;
  logic [TAG_W-1:0] tag8;
  side_t            side8;

  lbc_div #(
    .TAG_W (TAG_W)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .nx_i  (nx7_q),
    .ny_i  (ny7_q),
    .den_i (d7_q),
    .tag_i (side7_q),
    .qx_o  (qx8),
    .qy_o  (qy8),
    .tag_o (tag8)
  );

  assign side8 = side_t'(tag8);

  // velocity and equilibrium terms
  post_t pu_q [10];
  post_t pu0_d;

  logic signed [31:0] ux1_d, uy1_d, ux1_q, uy1_q, ux2_q, uy2_q, ux3_q, uy3_q;
  logic [31:0]        mux2_d, muy2_d, ms2_d, md2_d, mux2_q, muy2_q, ms2_q, md2_q;
  logic [63:0]        sqx3_q, sqy3_q, sqs3_q, sqd3_q;

  always_comb begin
    logic signed [31:0] qxs, qys;
    qxs = $signed({1'b0, qx8});
    qys = $signed({1'b0, qy8});
    ux1_d = side8.nz ? (side8.sx ? -qxs : qxs) : '0;
    uy1_d = side8.nz ? (side8.sy ? -qys : qys) : '0;
    pu0_d.f      = side8.f;
    pu0_d.rho    = side8.rho;
    pu0_d.capped = side8.capped;
  end

  always_comb begin
    logic signed [32:0] s, df;
    s      = 33'(ux1_q) + 33'(uy1_q);
    df     = 33'(ux1_q) - 33'(uy1_q);
    mux2_d = ux1_q[31] ? -ux1_q : ux1_q;
    muy2_d = uy1_q[31] ? -uy1_q : uy1_q;
    ms2_d  = s[32] ? 32'(-s) : 32'(s);
    md2_d  = df[32] ? 32'(-df) : 32'(df);
  end

  logic signed [P_W-1:0] p4_d [NDIR], p4_q [NDIR];

  always_comb begin
    logic signed [33:0]    eu;
    logic [63:0]           sq;
    logic [64:0]           e2w, uw;
    logic [34:0]           eu2, usq;
    logic [P_W-1:0]        e9, u3;
    uw  = 65'(sqx3_q) + 65'(sqy3_q) + (65'd1 << (U_FRAC - 1));
    usq = uw[64:U_FRAC];
    u3  = (P_W'(usq) * P_W'(3) + P_W'(1)) >> 1;
    for (int i = 0; i < NDIR; i++) begin
      eu = '0;
      if (DIR_X[i] > 0) eu = eu + ux3_q;
      else if (DIR_X[i] < 0) eu = eu - ux3_q;
      if (DIR_Y[i] > 0) eu = eu + uy3_q;
      else if (DIR_Y[i] < 0) eu = eu - uy3_q;
      if (DIR_X[i] == 0 && DIR_Y[i] == 0) sq = '0;
      else if (DIR_X[i] == 0) sq = sqy3_q;
      else if (DIR_Y[i] == 0) sq = sqx3_q;
      else if (DIR_X[i] == DIR_Y[i]) sq = sqs3_q;
      else sq = sqd3_q;
      e2w = {1'b0, sq} + (65'd1 << (U_FRAC - 1));
      eu2 = e2w[64:U_FRAC];
      e9  = (P_W'(eu2) * P_W'(9) + P_W'(1)) >> 1;
      p4_d[i] = $signed(P_W'(1) << U_FRAC) + P_W'(eu) * $signed(P_W'(3))
                + $signed(e9) - $signed(u3);
    end
  end

  // weight division by reciprocal
  logic [Y_W-1:0]           y5_d [NDIR], y5_q [NDIR];
  logic                     n5_d [NDIR], n5_q [NDIR], n6_q [NDIR];
  logic [Y_W+RCP_LO-1:0]    pl6_d [NDIR], pl6_q [NDIR];
  logic [PR_W-RCP_LO-1:0]   ph6_d [NDIR], ph6_q [NDIR];
  logic signed [WP_W-1:0]   wp7_d [NDIR], wp7_q [NDIR];
  logic signed [K_W-1:0]    k8_d [NDIR], k8_q [NDIR];

  always_comb begin
    logic signed [X_W-1:0] xs;
    logic [X_W-1:0]        mag;
    logic [RCP_W-1:0]      m;
    logic [PR_W-1:0]       prod;
    logic [PR_W-RCP_SH-1:0] q;
    for (int i = 0; i < NDIR; i++) begin
      xs  = X_W'(p4_q[i]) * $signed(X_W'(WT_NUM[i]));
      mag = xs[X_W-1] ? -xs : xs;
      n5_d[i] = xs[X_W-1];
      y5_d[i] = Y_W'(mag) + Y_W'(WT_DEN[i] / 2);
      m = (WT_DEN[i] == 9) ? RCP_9 : RCP_36;
      pl6_d[i] = (Y_W+RCP_LO)'(y5_q[i]) * (Y_W+RCP_LO)'(m[RCP_LO-1:0]);
      ph6_d[i] = (PR_W-RCP_LO)'(y5_q[i]) * (PR_W-RCP_LO)'(m[RCP_W-1:RCP_LO]);
      prod = (PR_W'(ph6_q[i]) << RCP_LO) + PR_W'(pl6_q[i]);
      q    = prod[PR_W-1:RCP_SH];
      wp7_d[i] = n6_q[i] ? -$signed(WP_W'(q)) : $signed(WP_W'(q));
      k8_d[i]  = $signed({1'b0, omega_q}) * wp7_q[i];
    end
  end

  // relaxation products
  logic signed [FCW-1:0] fc9_d [NDIR], fc9_q [NDIR];
  logic signed [PLW-1:0] pl9_d [NDIR], pl9_q [NDIR];
  logic signed [PHW-1:0] ph9_d [NDIR], ph9_q [NDIR];
  logic signed [TW-1:0]  t10_d [NDIR], t10_q [NDIR];
  logic [NDIR-1:0][DW-1:0] g_d, g_q;
  logic                  cap_q;

  always_comb begin
    logic signed [17:0]      c;
    logic signed [SW-1:0]    rho;
    logic signed [K_W-KLO_W-1:0] khi;
    logic signed [TW-1:0]    sh;
    c   = 18'sd65536 - $signed({1'b0, omega_q});
    rho = $signed(pu_q[7].rho);
    for (int i = 0; i < NDIR; i++) begin
      khi = k8_q[i][K_W-1:KLO_W];
      fc9_d[i] = $signed(pu_q[7].f[i]) * c;
      pl9_d[i] = rho * $signed({1'b0, k8_q[i][KLO_W-1:0]});
      ph9_d[i] = rho * khi;
      t10_d[i] = (TW'(fc9_q[i]) <<< U_FRAC) + (TW'(ph9_q[i]) <<< KLO_W) + TW'(pl9_q[i]);
      sh = (t10_q[i] + RND) >>> OUT_SHIFT;
      if (sh > GMAX) g_d[i] = GMAX[DW-1:0];
      else if (sh < GMIN) g_d[i] = GMIN[DW-1:0];
      else g_d[i] = sh[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pu_q[0] <= pu0_d;
      for (int k = 1; k < 10; k++) pu_q[k] <= pu_q[k-1];
      ux1_q  <= ux1_d;
      uy1_q  <= uy1_d;
      ux2_q  <= ux1_q;
      uy2_q  <= uy1_q;
      mux2_q <= mux2_d;
      muy2_q <= muy2_d;
      ms2_q  <= ms2_d;
      md2_q  <= md2_d;
      ux3_q  <= ux2_q;
      uy3_q  <= uy2_q;
      sqx3_q <= 64'(mux2_q) * 64'(mux2_q);
      sqy3_q <= 64'(muy2_q) * 64'(muy2_q);
      sqs3_q <= 64'(ms2_q) * 64'(ms2_q);
      sqd3_q <= 64'(md2_q) * 64'(md2_q);
      for (int i = 0; i < NDIR; i++) begin
        p4_q[i]  <= p4_d[i];
        y5_q[i]  <= y5_d[i];
        n5_q[i]  <= n5_d[i];
        n6_q[i]  <= n5_q[i];
        pl6_q[i] <= pl6_d[i];
        ph6_q[i] <= ph6_d[i];
        wp7_q[i] <= wp7_d[i];
        k8_q[i]  <= k8_d[i];
        fc9_q[i] <= fc9_d[i];
        pl9_q[i] <= pl9_d[i];
        ph9_q[i] <= ph9_d[i];
        t10_q[i] <= t10_d[i];
      end
      g_q   <= g_d;
      cap_q <= pu_q[9].capped;
    end
  end

  assign m_tdata = TD_W'(g_q);
  assign m_tuser = cap_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid |-> s_tready)
    else $error("input blocked while output register is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && !m_tready) |=> $stable(vld_q))
    else $error("pipeline moved during an output stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid && s_tready) |=> vld_q[0])
    else $error("accepted request missing from first stage");

endmodule

### hdl/lbc_isqrt.sv
// pipelined integer square root, one result bit per stage
module lbc_isqrt import lbc_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic [ROOT_W-1:0] root_o,
  output logic [TAG_W-1:0]  tag_o
);

  logic [RAD_W-1:0] n_q   [ROOT_W];
  logic [RAD_W-1:0] r_q   [ROOT_W];
  logic [TAG_W-1:0] tag_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
    logic [RAD_W-1:0] n_in;
    logic [RAD_W-1:0] r_in;
    logic [RAD_W-1:0] trial;
    logic [TAG_W-1:0] t_in;
    if (k == 0) begin : g_first
      assign n_in = rad_i;
      assign r_in = '0;
      assign t_in = tag_i;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign r_in = r_q[k-1];
      assign t_in = tag_q[k-1];
    end
    assign trial = r_in + BIT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[k] <= t_in;
        if (n_in >= trial) begin
          n_q[k] <= n_in - trial;
          r_q[k] <= (r_in >> 1) + BIT;
        end else begin
          n_q[k] <= n_in;
          r_q[k] <= r_in >> 1;
        end
      end
    end
  end

  assign root_o = r_q[ROOT_W-1][ROOT_W-1:0];
  assign tag_o  = tag_q[ROOT_W-1];

endmodule

### hdl/lbc_div.sv
// pipelined restoring divider, two numerators over one divisor, one bit per stage
module lbc_div import lbc_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] nx_i,
  input  logic [NUM_W-1:0] ny_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic [QUO_W-1:0] qx_o,
  output logic [QUO_W-1:0] qy_o,
  output logic [TAG_W-1:0] tag_o
);

  logic [NUM_W-1:0] nx_q  [QUO_W];
  logic [NUM_W-1:0] ny_q  [QUO_W];
  logic [DEN_W-1:0] rx_q  [QUO_W];
  logic [DEN_W-1:0] ry_q  [QUO_W];
  logic [QUO_W-1:0] qx_q  [QUO_W];
  logic [QUO_W-1:0] qy_q  [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [TAG_W-1:0] tag_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_st
    logic [NUM_W-1:0] nx_in, ny_in;
    logic [DEN_W-1:0] rx_in, ry_in, d_in;
    logic [QUO_W-1:0] qx_in, qy_in;
    logic [TAG_W-1:0] t_in;
    logic [DEN_W:0]   tx, ty;
    logic             gx, gy;
    if (k == 0) begin : g_first
      assign nx_in = nx_i;
      assign ny_in = ny_i;
      assign rx_in = DEN_W'(nx_i[NUM_W-1:QUO_W]);
      assign ry_in = DEN_W'(ny_i[NUM_W-1:QUO_W]);
      assign qx_in = '0;
      assign qy_in = '0;
      assign d_in  = den_i;
      assign t_in  = tag_i;
    end else begin : g_next
      assign nx_in = nx_q[k-1];
      assign ny_in = ny_q[k-1];
      assign rx_in = rx_q[k-1];
      assign ry_in = ry_q[k-1];
      assign qx_in = qx_q[k-1];
      assign qy_in = qy_q[k-1];
      assign d_in  = den_q[k-1];
      assign t_in  = tag_q[k-1];
    end
    assign tx = {rx_in, nx_in[QUO_W-1-k]};
    assign ty = {ry_in, ny_in[QUO_W-1-k]};
    assign gx = tx >= {1'b0, d_in};
    assign gy = ty >= {1'b0, d_in};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nx_q[k]  <= nx_in;
        ny_q[k]  <= ny_in;
        den_q[k] <= d_in;
        tag_q[k] <= t_in;
        rx_q[k]  <= gx ? DEN_W'(tx - {1'b0, d_in}) : DEN_W'(tx);
        ry_q[k]  <= gy ? DEN_W'(ty - {1'b0, d_in}) : DEN_W'(ty);
        qx_q[k]  <= {qx_in[QUO_W-2:0], gx};
        qy_q[k]  <= {qy_in[QUO_W-2:0], gy};
      end
    end
  end

  assign qx_o  = qx_q[QUO_W-1];
  assign qy_o  = qy_q[QUO_W-1];
  assign tag_o = tag_q[QUO_W-1];

endmodule
